### sv/assert_macros.svh
// Assertion macros shared by the list engine modules.
// Both expect a clock named clk in scope; ASSERT_RST also expects an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/bile_pkg.sv
package bile_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int RES_W = 7;

    // Search result when the word is absent or the command is not a search.
    localparam logic [RES_W-1:0] FOUND_NONE = '1;

    typedef enum logic [CMD_W-1:0] {
        OP_CLEAR       = 3'd0,
        OP_ADD         = 3'd1,
        OP_RM_FAST     = 3'd2,
        OP_RM_STABLE   = 3'd3,
        OP_FIND_FIRST  = 3'd4,
        OP_FIND_LAST   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        INIT_FIRST,
        INIT_LAST,
        INIT_SHIFT
    } init_sel_t;

    typedef struct packed {
        logic      load;
        logic      clr;
        logic      add;
        logic      dec;
        logic      batch_end;
        logic      init;
        init_sel_t init_sel;
        logic      scan_step;
        logic      shift_wr;
        logic      fast_rd;
        logic      fast_wr;
        logic      fin;
        logic      fin_ok;
        logic      fin_hit;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_ok;
        logic pos_last;
        logic hit;
        logic at_end;
    } stat_t;

endpackage

### sv/bile_ctrl.sv
`include "assert_macros.svh"

module bile_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bile_pkg::CMD_W-1:0]   cmd,
    input  logic                         batch_last,
    input  bile_pkg::stat_t              stat,
    output bile_pkg::ctrl_t              ctrl,
    output logic                         busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FAST_RD,
        S_FAST_WR,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             busy_reg;
    logic             accept;
    bile_pkg::op_t    op;

    assign op     = bile_pkg::op_t'(cmd);
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load = 1'b1;
                    unique case (op)
                        bile_pkg::OP_CLEAR:
                        begin
                            ctrl.clr = 1'b1;
                            ctrl.fin = 1'b1;
                        end
                        bile_pkg::OP_ADD:
                        begin
                            ctrl.add       = !stat.full;
                            ctrl.fin       = 1'b1;
                            ctrl.fin_ok    = !stat.full;
                            ctrl.batch_end = batch_last;
                        end
                        bile_pkg::OP_RM_FAST:
                        begin
                            if (stat.pos_ok)
                            begin
                                ctrl.dec   = 1'b1;
                                state_next = S_FAST_RD;
                            end
                            else
                            begin
                                ctrl.fin = 1'b1;
                            end
                        end
                        bile_pkg::OP_RM_STABLE:
                        begin
                            priority if (!stat.pos_ok)
                            begin
                                ctrl.fin = 1'b1;
                            end
                            else if (stat.pos_last)
                            begin
                                // Removing the top entry needs no shifting.
                                ctrl.dec    = 1'b1;
                                ctrl.fin    = 1'b1;
                                ctrl.fin_ok = 1'b1;
                            end
                            else
                            begin
                                ctrl.dec      = 1'b1;
                                ctrl.init     = 1'b1;
                                ctrl.init_sel = bile_pkg::INIT_SHIFT;
                                state_next    = S_SHIFT;
                            end
                        end
                        bile_pkg::OP_FIND_FIRST,
                        bile_pkg::OP_FIND_LAST:
                        begin
                            if (stat.empty)
                            begin
                                ctrl.fin = 1'b1;
                            end
                            else
                            begin
                                ctrl.init     = 1'b1;
                                ctrl.init_sel = (op == bile_pkg::OP_FIND_LAST) ?
                                                bile_pkg::INIT_LAST : bile_pkg::INIT_FIRST;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            ctrl.fin = 1'b1;
                        end
                    endcase
                end
            end
            S_FAST_RD:
            begin
                ctrl.fast_rd = 1'b1;
                state_next   = S_FAST_WR;
            end
            S_FAST_WR:
            begin
                ctrl.fast_wr = 1'b1;
                ctrl.fin     = 1'b1;
                ctrl.fin_ok  = 1'b1;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                priority if (stat.hit)
                begin
                    ctrl.fin     = 1'b1;
                    ctrl.fin_hit = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.at_end)
                begin
                    ctrl.fin   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Once a word has been read, each cycle writes the word read in the previous one, one slot lower.
                ctrl.shift_wr = 1'b1;
                if (stat.at_end)
                begin
                    ctrl.fin    = 1'b1;
                    ctrl.fin_ok = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    `ASSERT_RST(a_busy_matches_state, busy_reg == (state_reg != S_IDLE), "busy out of step with state")
    `ASSERT_RST(a_fin_returns_idle, (state_reg != S_IDLE && ctrl.fin) |=> (state_reg == S_IDLE), "no return to idle after a finished command")

endmodule

### sv/bile_dp.sv
`include "assert_macros.svh"

module bile_dp
#(
    parameter int CAPACITY = bile_pkg::CAPACITY_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  bile_pkg::ctrl_t                     ctrl,
    output bile_pkg::stat_t                     stat,
    input  logic signed [bile_pkg::VAL_W-1:0]   value,
    input  logic [bile_pkg::POS_W-1:0]          position,
    output logic                                done,
    output logic                                ok,
    output logic signed [bile_pkg::RES_W-1:0]   found_position,
    output logic [bile_pkg::RES_W-1:0]          fill_count,
    output logic [bile_pkg::RES_W-1:0]          batch_accepted
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > bile_pkg::POS_W) ? CW : bile_pkg::POS_W;

    logic [bile_pkg::VAL_W-1:0]  mem [CAPACITY];

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               batch_reg;
    logic [CW-1:0]               batch_next;
    logic [CW-1:0]               batch_upd;

    logic [AW-1:0]               ptr_reg;
    logic [AW-1:0]               chk_reg;
    logic [AW-1:0]               end_reg;
    logic                        down_reg;
    logic                        chk_valid_reg;
    logic [bile_pkg::VAL_W-1:0]  value_reg;
    logic [AW-1:0]               pos_reg;
    logic [bile_pkg::VAL_W-1:0]  rd_data_reg;

    logic                        done_reg;
    logic                        ok_reg;
    logic [bile_pkg::RES_W-1:0]  found_reg;
    logic [bile_pkg::RES_W-1:0]  fill_reg;
    logic [bile_pkg::RES_W-1:0]  batch_out_reg;

    logic [XW-1:0]               pos_ext;
    logic [XW-1:0]               cnt_ext;
    logic                        we;
    logic                        re;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [bile_pkg::VAL_W-1:0]  wdata;

    assign pos_ext = XW'(position);
    assign cnt_ext = XW'(count_reg);

    always_comb
    begin
        stat.full     = (count_reg == CW'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.pos_ok   = (pos_ext < cnt_ext);
        stat.pos_last = ((pos_ext + XW'(1)) == cnt_ext);
        stat.hit      = chk_valid_reg && (rd_data_reg == value_reg);
        stat.at_end   = chk_valid_reg && (chk_reg == end_reg);
    end

    always_comb
    begin
        priority if (ctrl.clr)
        begin
            count_next = '0;
        end
        else if (ctrl.add)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.dec)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // The batch count saturates at the capacity and clears after the closing add.
    assign batch_upd  = (ctrl.add && batch_reg != CW'(CAPACITY)) ? batch_reg + CW'(1) : batch_reg;
    assign batch_next = ctrl.batch_end ? '0 : batch_upd;

    always_comb
    begin
        we    = ctrl.add || ctrl.fast_wr || (ctrl.shift_wr && chk_valid_reg);
        re    = ctrl.scan_step || ctrl.fast_rd;
        raddr = ctrl.fast_rd ? count_reg[AW-1:0] : ptr_reg;
        priority if (ctrl.add)
        begin
            waddr = count_reg[AW-1:0];
            wdata = value;
        end
        else if (ctrl.fast_wr)
        begin
            waddr = pos_reg;
            wdata = rd_data_reg;
        end
        else
        begin
            waddr = chk_reg - AW'(1);
            wdata = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= value;
            pos_reg   <= pos_ext[AW-1:0];
        end
        if (ctrl.init)
        begin
            unique case (ctrl.init_sel)
                bile_pkg::INIT_FIRST:
                begin
                    ptr_reg <= '0;
                    end_reg <= AW'(count_reg - CW'(1));
                end
                bile_pkg::INIT_LAST:
                begin
                    ptr_reg <= AW'(count_reg - CW'(1));
                    end_reg <= '0;
                end
                bile_pkg::INIT_SHIFT:
                begin
                    ptr_reg <= AW'(pos_ext + XW'(1));
                    end_reg <= AW'(count_reg - CW'(1));
                end
                default:
                begin
                    ptr_reg <= '0;
                    end_reg <= '0;
                end
            endcase
            down_reg <= (ctrl.init_sel == bile_pkg::INIT_LAST);
        end
        else if (ctrl.scan_step)
        begin
            chk_reg <= ptr_reg;
            ptr_reg <= down_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
        end
        if (ctrl.fin)
        begin
            ok_reg        <= ctrl.fin_ok;
            found_reg     <= ctrl.fin_hit ? bile_pkg::RES_W'(chk_reg) : bile_pkg::FOUND_NONE;
            fill_reg      <= bile_pkg::RES_W'(count_next);
            batch_out_reg <= bile_pkg::RES_W'(batch_upd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            batch_reg     <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            batch_reg <= batch_next;
            done_reg  <= ctrl.fin;
            if (ctrl.init)
            begin
                chk_valid_reg <= 1'b0;
            end
            else if (ctrl.scan_step)
            begin
                chk_valid_reg <= 1'b1;
            end
        end
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign found_position = found_reg;
    assign fill_count     = fill_reg;
    assign batch_accepted = batch_out_reg;

    `ASSERT_RST(a_count_bound, count_reg <= CW'(CAPACITY), "fill count above capacity")
    `ASSERT_RST(a_batch_bound, batch_reg <= CW'(CAPACITY), "batch count above capacity")
    `ASSERT_RST(a_read_in_list, ctrl.scan_step |-> (ptr_reg <= count_reg), "scan reads beyond the list")

endmodule

### sv/bounded_integer_list_engine.sv
// Fixed-capacity list of signed 32-bit words, driven one command at a time.
// A command transfers at a rising edge with start high and busy low; cmd,
// value, position and batch_last are sampled at that edge.
// Every command gives one result: done is high for exactly one cycle with
// ok, found_position, fill_count and batch_accepted valid alongside it.
// The receiver cannot stall, so the result must be taken in that cycle.
// Steps from transfer to done:
//   clear, add, rejected removal, stable removal of the top entry and
//   search of an empty list: finished directly from the idle state;
//   fast removal: one memory read, then one write;
//   stable removal: one shift step per entry above the slot;
//   find first/last: one step per entry examined, at most fill entries.
// Searches and stable removal step through the entry memory one word per
// cycle through its single read port and so set the worst case. busy stays
// low for idle-finished commands, which can follow in consecutive cycles.
// Reset empties the list and the batch count; the entry memory itself is
// not cleared and needs no clearing pass.
module bounded_integer_list_engine
#(
    parameter int CAPACITY = bile_pkg::CAPACITY_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bile_pkg::CMD_W-1:0]          cmd,
    input  logic signed [bile_pkg::VAL_W-1:0]   value,
    input  logic [bile_pkg::POS_W-1:0]          position,
    input  logic                                batch_last,
    output logic                                busy,
    output logic                                done,
    output logic                                ok,
    output logic signed [bile_pkg::RES_W-1:0]   found_position,
    output logic [bile_pkg::RES_W-1:0]          fill_count,
    output logic [bile_pkg::RES_W-1:0]          batch_accepted
);

    bile_pkg::ctrl_t ctrl;
    bile_pkg::stat_t stat;

    bile_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .batch_last (batch_last),
        .stat       (stat),
        .ctrl       (ctrl),
        .busy       (busy)
    );

    bile_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .value          (value),
        .position       (position),
        .done           (done),
        .ok             (ok),
        .found_position (found_position),
        .fill_count     (fill_count),
        .batch_accepted (batch_accepted)
    );

endmodule
